### rtl/lje_pkg.sv
// Package for the Lennard-Jones probe energy unit: job type, codes and the
// mixed-parameter ROM. Used by the top, front, queue and back modules; depends on nothing.
`default_nettype none
package lje_pkg;
	localparam int QUEUE_DEPTH = 4;
	localparam int ELEMENT_CLASSES = 8;
	localparam int CFG_WIDTH = 39;
	localparam int POT_WIDTH = 48;
	localparam logic [POT_WIDTH-1:0] E_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [CFG_WIDTH-1:0] EXIT_THRESHOLD_RESET = 39'd256000;
	localparam logic [CFG_WIDTH-1:0] COINCIDENT_RESET = 39'd256000000000;

	localparam logic OP_START = 1'b0;
	localparam logic REG_EXIT_THRESHOLD = 1'b0;
	localparam logic REG_COINCIDENT = 1'b1;

	localparam logic [1:0] ST_FULL = 2'd0;
	localparam logic [1:0] ST_EXIT = 2'd1;
	localparam logic [1:0] ST_COINC = 2'd2;

	localparam logic [2:0] CLASS_DEFAULT = 3'd7;

	typedef struct packed {
		logic        start;
		logic        last;
		logic [2:0]  cls;
		logic [63:0] r2;
	} job_t;

	function automatic logic [29:0] sig2_rom(input logic [2:0] c);
		logic [29:0] v;
		case (c)
			3'd0:    v = 30'd497228632;
			3'd1:    v = 30'd435007441;
			3'd2:    v = 30'd475549785;
			3'd3:    v = 30'd374403305;
			3'd4:    v = 30'd621009590;
			3'd5:    v = 30'd380770594;
			3'd6:    v = 30'd293138229;
			default: v = 30'd497228632;
		endcase
		return v;
	endfunction

	function automatic logic [16:0] eps4_rom(input logic [2:0] c);
		logic [16:0] v;
		case (c)
			3'd0:    v = 17'd59307;
			3'd1:    v = 17'd86817;
			3'd2:    v = 17'd67248;
			3'd3:    v = 17'd43408;
			3'd4:    v = 17'd65353;
			3'd5:    v = 17'd88252;
			3'd6:    v = 17'd54908;
			default: v = 17'd79253;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

### rtl/lennard_jones_probe_energy_unit.sv
// Top level of the Lennard-Jones probe energy unit: ports, registers, wiring.
// Depends on lje_pkg, lje_front, lje_fifo and lje_back.
//
//   channel  | signals                              | moves
//   s_*      | tvalid tready tdata tuser tlast      | probe start or atom item
//   m_*      | tvalid tready tdata tuser            | energy result item
//   wr_*     | wr_en wr_index wr_data               | register write
//
// The front takes a new item only after it has pushed the last one; a 4-entry queue decouples it.
// Back: an atom goes through the 27-step bit-serial divider and one 32x32
// multiplier over 20 partial products; a close atom skips both.
// Reset clears probe, sum, flags and queue; registers return to their defaults.
// A result waiting on m_tready stalls only the back; the front keeps filling the queue.
`default_nettype none
module lennard_jones_probe_energy_unit #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// x_coord, y_coord, z_coord, element_class, zero fill
	input  wire logic [((3*COORD_WIDTH+3+7)/8)*8-1:0] s_tdata,
	// operation
	input  wire logic                                 s_tuser,
	input  wire logic                                 s_tlast,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// potential
	output logic [lje_pkg::POT_WIDTH-1:0]             m_tdata,
	// status
	output logic [1:0]                                m_tuser,
	input  wire logic                                 wr_en,
	input  wire logic                                 wr_index,
	input  wire logic [lje_pkg::CFG_WIDTH-1:0]        wr_data
);
	localparam int CW = COORD_WIDTH;

	logic [lje_pkg::CFG_WIDTH-1:0] thr_q;
	logic [lje_pkg::CFG_WIDTH-1:0] coin_q;
	logic                          push;
	logic                          full;
	logic                          pop;
	logic                          job_valid;
	lje_pkg::job_t                 job_in;
	lje_pkg::job_t                 job_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= lje_pkg::EXIT_THRESHOLD_RESET;
			coin_q <= lje_pkg::COINCIDENT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				lje_pkg::REG_EXIT_THRESHOLD: thr_q  <= wr_data;
				lje_pkg::REG_COINCIDENT:     coin_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	lje_front #(.COORD_WIDTH(CW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.op       (s_tuser),
		.x        ($signed(s_tdata[CW-1:0])),
		.y        ($signed(s_tdata[2*CW-1:CW])),
		.z        ($signed(s_tdata[3*CW-1:2*CW])),
		.cls      (s_tdata[3*CW+2:3*CW]),
		.last     (s_tlast),
		.push     (push),
		.full     (full),
		.job      (job_in)
	);

	lje_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_in),
		.full   (full),
		.pop    (pop),
		.valid  (job_valid),
		.dout   (job_out)
	);

	lje_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.job_valid        (job_valid),
		.job              (job_out),
		.pop              (pop),
		.exit_threshold   (thr_q),
		.coincident_value (coin_q),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.potential        (m_tdata),
		.status           (m_tuser)
	);
endmodule
`default_nettype wire

### rtl/lje_fifo.sv
// Job queue between front and back of the probe energy unit.
// Depends on lje_pkg for the job type and depth.
`default_nettype none
module lje_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lje_pkg::job_t din,
	output logic               full,
	input  wire logic          pop,
	output logic               valid,
	output lje_pkg::job_t      dout
);
	localparam int AW = $clog2(lje_pkg::QUEUE_DEPTH);

	lje_pkg::job_t      mem_q [lje_pkg::QUEUE_DEPTH];
	logic [AW-1:0]      wr_q;
	logic [AW-1:0]      rd_q;
	logic [AW:0]        cnt_q;

	assign full  = (cnt_q == (AW+1)'(lje_pkg::QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == AW'(lje_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && valid) begin
				rd_q <= (rd_q == AW'(lje_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && valid);
		end
	end
endmodule
`default_nettype wire

### rtl/lje_front.sv
// Front of the probe energy unit: takes items, holds the probe and forms r^2.
// Depends on lje_pkg; feeds lje_fifo.
`default_nettype none
module lje_front #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          op,
	input  wire logic signed [COORD_WIDTH-1:0] x,
	input  wire logic signed [COORD_WIDTH-1:0] y,
	input  wire logic signed [COORD_WIDTH-1:0] z,
	input  wire logic [2:0]                    cls,
	input  wire logic                          last,
	output logic                               push,
	input  wire logic                          full,
	output lje_pkg::job_t                      job
);
	localparam int CW = COORD_WIDTH;
	localparam int EW = (CW + 1 > 33) ? CW + 1 : 33;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_DIFF = 4'b0010,
		F_SQ   = 4'b0100,
		F_PUSH = 4'b1000
	} fst_t;

	fst_t                   state_q;
	logic signed [CW-1:0]   probe_q [3];
	logic signed [CW-1:0]   coord_q [3];
	logic [31:0]            mag_q [3];
	logic                   big_q [3];
	logic [1:0]             axis_q;
	logic [63:0]            r2_q;
	logic                   start_q;
	logic                   last_q;
	logic [2:0]             cls_q;

	logic signed [CW:0]     diff [3];
	logic [EW-1:0]          absd [3];
	logic [63:0]            sq;
	logic [64:0]            sum;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {coord_q[i][CW-1], coord_q[i]} - {probe_q[i][CW-1], probe_q[i]};
			absd[i] = EW'(diff[i][CW] ? $unsigned(-diff[i]) : $unsigned(diff[i]));
		end
		sq  = big_q[axis_q] ? '1 : {32'b0, mag_q[axis_q]} * {32'b0, mag_q[axis_q]};
		sum = {1'b0, r2_q} + {1'b0, sq};
	end

	assign in_ready = (state_q == F_IDLE);
	assign push     = (state_q == F_PUSH);
	assign job      = '{start: start_q, last: last_q, cls: cls_q, r2: r2_q};

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				coord_q[0] <= x;
				coord_q[1] <= y;
				coord_q[2] <= z;
				start_q    <= (op == lje_pkg::OP_START);
				last_q     <= last;
				cls_q      <= cls;
				r2_q       <= '0;
				axis_q     <= '0;
			end
			F_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= absd[i][31:0];
					big_q[i] <= |absd[i][EW-1:32];
				end
			end
			F_SQ: begin
				r2_q   <= sum[64] ? '1 : sum[63:0];
				axis_q <= axis_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			for (int i = 0; i < 3; i++) probe_q[i] <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						if (op == lje_pkg::OP_START) begin
							probe_q[0] <= x;
							probe_q[1] <= y;
							probe_q[2] <= z;
							state_q    <= F_PUSH;
						end else begin
							state_q <= F_DIFF;
						end
					end
				end
				F_DIFF:  state_q <= F_SQ;
				F_SQ:    if (axis_q == 2'd2) state_q <= F_PUSH;
				F_PUSH:  if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/lje_back.sv
// Back of the probe energy unit: divider, shared multiplier, sum and result.
// Depends on lje_pkg; drains lje_fifo.
`default_nettype none
module lje_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               job_valid,
	input  wire lje_pkg::job_t                      job,
	output logic                                    pop,
	input  wire logic [lje_pkg::CFG_WIDTH-1:0]      exit_threshold,
	input  wire logic [lje_pkg::CFG_WIDTH-1:0]      coincident_value,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [lje_pkg::POT_WIDTH-1:0]           potential,
	output logic [1:0]                              status
);
	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_EVAL = 7'b0000010,
		B_DIV  = 7'b0000100,
		B_MUL  = 7'b0001000,
		B_DIFF = 7'b0010000,
		B_SUM  = 7'b0100000,
		B_FIN  = 7'b1000000
	} bst_t;

	bst_t               state_q;
	lje_pkg::job_t      job_q;
	logic [63:0]        rem_q;
	logic [26:0]        nlo_q;
	logic [4:0]         cnt_q;
	logic [26:0]        q_q;
	logic [29:0]        q2_q;
	logic [35:0]        q4_q;
	logic [41:0]        q6_q;
	logic [59:0]        q12_q;
	logic [59:0]        diff_q;
	logic               neg_q;
	logic [52:0]        mag_q;
	logic               capped_q;
	logic [2:0]         step_q;
	logic [1:0]         pp_q;
	logic [127:0]       acc_q;
	logic signed [47:0] sum_q;
	logic               stopped_q;
	logic [1:0]         status_q;
	logic               out_valid_q;
	logic [47:0]        out_pot_q;
	logic [1:0]         out_st_q;

	logic [2:0]         cls_eff;
	logic [29:0]        sig2;
	logic               cap;
	logic [64:0]        trial;
	logic [64:0]        trial_sub;
	logic               ge;
	logic [63:0]        op_a;
	logic [63:0]        op_b;
	logic [31:0]        half_a;
	logic [31:0]        half_b;
	logic [63:0]        ppv;
	logic [127:0]       pp_sh;
	logic [127:0]       acc_nx;
	logic [47:0]        pmag;
	logic signed [48:0] pair;
	logic signed [48:0] s_raw;
	logic signed [47:0] s_cl;
	logic               emit;

	always_comb begin
		cls_eff = (32'(job_q.cls) >= lje_pkg::ELEMENT_CLASSES) ? lje_pkg::CLASS_DEFAULT
			: job_q.cls;
		sig2  = lje_pkg::sig2_rom(cls_eff);
		cap   = {37'b0, sig2, 24'b0} >= {job_q.r2, 27'b0};
		trial = {rem_q, nlo_q[cnt_q]};
		trial_sub = trial - {1'b0, job_q.r2};
		ge    = (trial >= {1'b0, job_q.r2});

		case (step_q)
			3'd0:    begin op_a = 64'(q_q);  op_b = 64'(q_q);  end
			3'd1:    begin op_a = 64'(q2_q); op_b = 64'(q2_q); end
			3'd2:    begin op_a = 64'(q4_q); op_b = 64'(q2_q); end
			3'd3:    begin op_a = 64'(q6_q); op_b = 64'(q6_q); end
			3'd4:    begin op_a = 64'(lje_pkg::eps4_rom(cls_eff)); op_b = 64'(diff_q); end
			default: begin op_a = '0; op_b = '0; end
		endcase
		half_a = pp_q[1] ? op_a[63:32] : op_a[31:0];
		half_b = pp_q[0] ? op_b[63:32] : op_b[31:0];
		ppv    = {32'b0, half_a} * {32'b0, half_b};
		case (pp_q)
			2'd0:    pp_sh = {64'b0, ppv};
			2'd3:    pp_sh = {ppv, 64'b0};
			default: pp_sh = {32'b0, ppv, 32'b0};
		endcase
		acc_nx = acc_q + pp_sh;

		pmag  = (mag_q > 53'(lje_pkg::E_MAX)) ? lje_pkg::E_MAX : mag_q[47:0];
		pair  = capped_q ? $signed({1'b0, lje_pkg::E_MAX})
			: (neg_q ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag}));
		s_raw = {sum_q[47], sum_q} + pair;
		if (s_raw > $signed({1'b0, lje_pkg::E_MAX})) begin
			s_cl = $signed(lje_pkg::E_MAX);
		end else if (s_raw < -$signed({1'b0, lje_pkg::E_MAX})) begin
			s_cl = -$signed(lje_pkg::E_MAX);
		end else begin
			s_cl = s_raw[47:0];
		end

		emit = (state_q == B_FIN) && job_q.last && (!out_valid_q || out_ready);
	end

	assign pop       = (state_q == B_IDLE);
	assign out_valid = out_valid_q;
	assign potential = out_pot_q;
	assign status    = out_st_q;

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: job_q <= job;
			B_EVAL: begin
				rem_q    <= {37'b0, sig2[29:3]};
				nlo_q    <= {sig2[2:0], 24'b0};
				cnt_q    <= 5'd26;
				capped_q <= cap;
				step_q   <= '0;
				pp_q     <= '0;
				acc_q    <= '0;
			end
			B_DIV: begin
				rem_q <= ge ? trial_sub[63:0] : trial[63:0];
				q_q   <= {q_q[25:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			B_MUL: begin
				pp_q <= pp_q + 1'b1;
				if (pp_q == 2'd3) begin
					acc_q  <= '0;
					step_q <= step_q + 1'b1;
					case (step_q)
						3'd0:    q2_q  <= acc_nx[24 +: 30];
						3'd1:    q4_q  <= acc_nx[24 +: 36];
						3'd2:    q6_q  <= acc_nx[24 +: 42];
						3'd3:    q12_q <= acc_nx[24 +: 60];
						default: mag_q <= acc_nx[24 +: 53];
					endcase
				end else begin
					acc_q <= acc_nx;
				end
			end
			B_DIFF: begin
				neg_q  <= q12_q < 60'(q6_q);
				diff_q <= (q12_q < 60'(q6_q)) ? 60'(q6_q) - q12_q : q12_q - 60'(q6_q);
			end
			default: begin
			end
		endcase
		if (emit) begin
			out_pot_q <= (status_q == lje_pkg::ST_COINC) ? 48'(coincident_value)
				: sum_q;
			out_st_q  <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			sum_q       <= '0;
			stopped_q   <= 1'b0;
			status_q    <= lje_pkg::ST_FULL;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: if (job_valid) state_q <= B_EVAL;
				B_EVAL: begin
					if (job_q.start) begin
						sum_q     <= '0;
						stopped_q <= 1'b0;
						status_q  <= lje_pkg::ST_FULL;
						state_q   <= B_FIN;
					end else if (stopped_q) begin
						state_q <= B_FIN;
					end else if (job_q.r2 == '0) begin
						status_q  <= lje_pkg::ST_COINC;
						stopped_q <= 1'b1;
						state_q   <= B_FIN;
					end else if (cap) begin
						state_q <= B_SUM;
					end else begin
						state_q <= B_DIV;
					end
				end
				B_DIV: if (cnt_q == '0) state_q <= B_MUL;
				B_MUL: begin
					if (pp_q == 2'd3) begin
						if (step_q == 3'd3) state_q <= B_DIFF;
						else if (step_q == 3'd4) state_q <= B_SUM;
					end
				end
				B_DIFF: state_q <= B_MUL;
				B_SUM: begin
					sum_q <= s_cl;
					if ($signed({s_cl[47], s_cl}) > $signed({10'b0, exit_threshold})) begin
						status_q  <= lje_pkg::ST_EXIT;
						stopped_q <= 1'b1;
					end
					state_q <= B_FIN;
				end
				B_FIN: begin
					if (!job_q.last) begin
						state_q <= B_IDLE;
					end else if (emit) begin
						sum_q     <= '0;
						stopped_q <= 1'b0;
						status_q  <= lje_pkg::ST_FULL;
						state_q   <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/lje_checker.sv
// Port-level checks on the result channel of the probe energy unit.
// Bound to lennard_jones_probe_energy_unit; depends on nothing else.
`default_nettype none
module lje_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3)
		else $error("undefined status code");

	a_exit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == 2'd1 |-> !m_tdata[47])
		else $error("early exit with negative sum");

	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result present out of reset");
endmodule

bind lennard_jones_probe_energy_unit lje_checker u_lje_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
